// ===== rtl/sct_pkg.sv =====
package sct_pkg;

  // input word kinds carried on in_tuser
  localparam logic [1:0] MODE_CIRCLE     = 2'd0;
  localparam logic [1:0] MODE_CIRCLE_END = 2'd1;

  // configuration register indexes
  localparam logic [2:0] REG_X_THR     = 3'd0;
  localparam logic [2:0] REG_Y_THR     = 3'd1;
  localparam logic [2:0] REG_R_THR     = 3'd2;
  localparam logic [2:0] REG_MATCH_THR = 3'd3;
  localparam logic [2:0] REG_FRAME_W   = 3'd4;
  localparam logic [2:0] REG_FRAME_H   = 3'd5;

  // register widths and field widths fixed by the interface
  localparam int THR_W    = 10;
  localparam int MATCH_W  = 3;
  localparam int DIM_W    = 12;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 3;

  // reset values of the configuration registers
  localparam logic [THR_W-1:0]   X_THR_RST     = 10'd60;
  localparam logic [THR_W-1:0]   Y_THR_RST     = 10'd60;
  localparam logic [THR_W-1:0]   R_THR_RST     = 10'd80;
  localparam logic [MATCH_W-1:0] MATCH_THR_RST = 3'd3;
  localparam logic [DIM_W-1:0]   FRAME_W_RST   = 12'd640;
  localparam logic [DIM_W-1:0]   FRAME_H_RST   = 12'd480;

  // similarity limits shared by every slot cell
  typedef struct packed {
    logic [THR_W-1:0] x_thr;
    logic [THR_W-1:0] y_thr;
    logic [THR_W-1:0] r_thr;
  } thr_t;

  // per-cycle control broadcast to the slot cells
  typedef struct packed {
    logic rd_en;      // read one stored entry this cycle
    logic walk_clr;   // start of a new walk, drop old hit flags
    logic store;      // write the current circle into the current slot
    logic frame_end;  // close the current slot and move on
  } cell_ctl_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

endpackage

// ===== rtl/sct_cell.sv =====
module sct_cell #(
  parameter int  MAX_CIRCLES = 16,
  parameter int  COORD_BITS  = 14,
  parameter int  HIST_W      = 3,
  parameter bit  START_CUR   = 1'b0
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  sct_pkg::cell_ctl_t                        ctl,
  input  sct_pkg::thr_t                             thr,
  input  logic                                      cur_prev,
  output logic                                      cur_out,
  input  logic [((MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1)-1:0] wr_addr,
  input  logic [3*COORD_BITS-1:0]                   wr_data,
  input  logic [$clog2(MAX_CIRCLES+1)-1:0]          end_count,
  input  logic [$clog2(MAX_CIRCLES+1)-1:0]          rd_idx,
  input  logic [COORD_BITS-1:0]                     probe_x,
  input  logic [COORD_BITS-1:0]                     probe_y,
  input  logic [COORD_BITS-1:0]                     probe_r,
  input  logic [HIST_W-1:0]                         cnt_in,
  output logic [HIST_W-1:0]                         cnt_out
);
  import sct_pkg::*;

  localparam int AW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CW = $clog2(MAX_CIRCLES + 1);
  localparam int TW = (COORD_BITS > THR_W) ? COORD_BITS : THR_W;

  logic [3*COORD_BITS-1:0] mem_r [MAX_CIRCLES];
  logic [3*COORD_BITS-1:0] rd_data_r;
  logic                    rd_ok_r;
  logic                    cur_r;
  logic                    valid_r;
  logic [CW-1:0]           count_r;
  logic                    hit_r;

  logic [COORD_BITS-1:0]   sx, sy, sr;
  logic [COORD_BITS-1:0]   dx, dy, dr;
  logic                    close;

  // slot storage
  always_ff @(posedge clk) begin
    if (ctl.store && cur_r) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_idx[AW-1:0]];
  end

  // current-slot token, history valid and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= START_CUR;
      valid_r <= 1'b0;
      count_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      rd_ok_r <= ctl.rd_en && valid_r && (rd_idx < count_r);
      if (ctl.frame_end) begin
        cur_r <= cur_prev;
        if (cur_r) begin
          valid_r <= 1'b1;
          count_r <= end_count;
        end else if (cur_prev) begin
          valid_r <= 1'b0;
        end
      end
    end
  end

  // compare the entry just read against the probe circle
  always_comb begin
    sx = rd_data_r[COORD_BITS-1:0];
    sy = rd_data_r[2*COORD_BITS-1:COORD_BITS];
    sr = rd_data_r[3*COORD_BITS-1:2*COORD_BITS];
    dx = (probe_x >= sx) ? probe_x - sx : sx - probe_x;
    dy = (probe_y >= sy) ? probe_y - sy : sy - probe_y;
    dr = (probe_r >= sr) ? probe_r - sr : sr - probe_r;
    close = (TW'(dx) < TW'(thr.x_thr)) &&
            (TW'(dy) < TW'(thr.y_thr)) &&
            (TW'(dr) < TW'(thr.r_thr));
  end

  // sticky hit over one walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.walk_clr) begin
      hit_r <= 1'b0;
    end else if (rd_ok_r && close) begin
      hit_r <= 1'b1;
    end
  end

  assign cur_out = cur_r;
  assign cnt_out = cnt_in + HIST_W'(hit_r);

endmodule

// ===== rtl/stable_circle_tracker.sv =====
// stable_circle_tracker
// Input stream: one word per circle (in_tdata holds x, y, radius in quarter
// pixels, in_tuser the kind: circle, circle closing the frame, or bare frame
// end). Output stream: exactly one word per input word, in order, with the
// echoed circle, the inside-image flag, the number of history frames that
// hold a similar circle, the stable flag, and tlast on the word closing a frame.
// Thresholds and image size are written through the cfg_ port while idle; the
// user must keep to this, as the block does not enforce it. History sits in a
// ring of HISTORY_DEPTH+1 slot cells; each cell keeps one frame of up to
// MAX_CIRCLES circles in its own memory, and the current-slot token passes to
// the neighbor cell at every frame end. A circle lying inside the image walks
// all slot memories in parallel, one entry per cycle, and no next word is
// taken until its result word is committed; other words skip the walk. The
// walk length is set by the single read port of each slot memory.
// A finished word sits in the output register while the next input word is
// already taken; if the receiver stalls, the block finishes that next word and
// waits with it until the output register frees up.
// Reset (rst_n low, synchronous) empties the history, restores the default
// register values and drops any pending output word.
module stable_circle_tracker #(
  parameter int HISTORY_DEPTH = 5,
  parameter int MAX_CIRCLES   = 16,
  parameter int COORD_BITS    = 14
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // in_tdata: centre_x, centre_y, radius, zero fill
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]        in_tdata,
  // in_tuser: mode
  input  logic [sct_pkg::MODE_W-1:0]               in_tuser,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // out_tdata: out_centre_x, out_centre_y, out_radius, inside_frame,
  // matched_frames, stable, zero fill
  output logic [((3*COORD_BITS+5+7)/8)*8-1:0]      out_tdata,
  // out_tuser: circle_present
  output logic                                     out_tuser,
  // out_tlast: frame_done
  output logic                                     out_tlast,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  input  logic                                     cfg_we,
  input  logic [sct_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [sct_pkg::DIM_W-1:0]                cfg_wdata
);
  import sct_pkg::*;

  localparam int SLOTS  = HISTORY_DEPTH + 1;
  localparam int AW     = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CW     = $clog2(MAX_CIRCLES + 1);
  localparam int HW     = $clog2(HISTORY_DEPTH + 1);
  localparam int SW     = (COORD_BITS + 1 > DIM_W + 2) ? COORD_BITS + 1 : DIM_W + 2;
  localparam int OUT_DW = ((3*COORD_BITS+5+7)/8)*8;
  localparam int CB     = COORD_BITS;

  // configuration registers
  thr_t               thr_r;
  logic [MATCH_W-1:0] match_thr_r;
  logic [DIM_W-1:0]   frame_w_r;
  logic [DIM_W-1:0]   frame_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.x_thr <= X_THR_RST;
      thr_r.y_thr <= Y_THR_RST;
      thr_r.r_thr <= R_THR_RST;
      match_thr_r <= MATCH_THR_RST;
      frame_w_r   <= FRAME_W_RST;
      frame_h_r   <= FRAME_H_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_THR:     thr_r.x_thr <= cfg_wdata[THR_W-1:0];
        REG_Y_THR:     thr_r.y_thr <= cfg_wdata[THR_W-1:0];
        REG_R_THR:     thr_r.r_thr <= cfg_wdata[THR_W-1:0];
        REG_MATCH_THR: match_thr_r <= cfg_wdata[MATCH_W-1:0];
        REG_FRAME_W:   frame_w_r   <= cfg_wdata;
        REG_FRAME_H:   frame_h_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input unpack and bounds check
  logic [CB-1:0] in_x, in_y, in_r;
  logic          in_has, in_ends, in_inside;
  logic [SW-1:0] sum_x, sum_y, lim_x, lim_y;

  always_comb begin
    in_x    = in_tdata[CB-1:0];
    in_y    = in_tdata[2*CB-1:CB];
    in_r    = in_tdata[3*CB-1:2*CB];
    in_has  = (in_tuser == MODE_CIRCLE) || (in_tuser == MODE_CIRCLE_END);
    in_ends = (in_tuser != MODE_CIRCLE);
    sum_x   = SW'(in_x) + SW'(in_r);
    sum_y   = SW'(in_y) + SW'(in_r);
    lim_x   = SW'({frame_w_r, 2'b00});
    lim_y   = SW'({frame_h_r, 2'b00});
    in_inside = in_has && (in_x >= in_r) && (in_y >= in_r) &&
                (sum_x < lim_x) && (sum_y < lim_y);
  end

  // sequencer and held item
  state_t        state_r, state_nxt;
  logic [CB-1:0] x_r, y_r, r_r;
  logic          has_r, ends_r, inside_r;
  logic [CW-1:0] walk_r, walk_nxt;
  logic [CW-1:0] cur_cnt_r, cur_cnt_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic          accept, commit, do_store;
  cell_ctl_t     ctl;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign commit    = (state_r == ST_HOLD) && (!out_tvalid_r || out_tready);
  assign do_store  = has_r && (cur_cnt_r < CW'(MAX_CIRCLES));

  always_comb begin
    state_nxt      = state_r;
    walk_nxt       = walk_r;
    cur_cnt_nxt    = cur_cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        walk_nxt = '0;
        if (accept) begin
          state_nxt = in_inside ? ST_WALK : ST_HOLD;
        end
      end
      ST_WALK: begin
        walk_nxt = walk_r + CW'(1);
        if (walk_r == CW'(MAX_CIRCLES - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_HOLD;
      ST_HOLD: begin
        if (commit) begin
          state_nxt      = ST_IDLE;
          out_tvalid_nxt = 1'b1;
          if (ends_r) begin
            cur_cnt_nxt = '0;
          end else if (do_store) begin
            cur_cnt_nxt = cur_cnt_r + CW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      walk_r       <= '0;
      cur_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      walk_r       <= walk_nxt;
      cur_cnt_r    <= cur_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r      <= in_x;
      y_r      <= in_y;
      r_r      <= in_r;
      has_r    <= in_has;
      ends_r   <= in_ends;
      inside_r <= in_inside;
    end
  end

  // cell control
  always_comb begin
    ctl.rd_en     = (state_r == ST_WALK);
    ctl.walk_clr  = accept;
    ctl.store     = commit && do_store;
    ctl.frame_end = commit && ends_r;
  end

  // ring of slot cells
  logic [SLOTS-1:0]  cur_vec;
  logic [HW-1:0]     cnt_chain [SLOTS+1];
  logic [CW-1:0]     end_count;
  logic [3*CB-1:0]   wr_data;

  assign end_count    = cur_cnt_r + CW'(do_store);
  assign wr_data      = {r_r, y_r, x_r};
  assign cnt_chain[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    sct_cell #(
      .MAX_CIRCLES (MAX_CIRCLES),
      .COORD_BITS  (COORD_BITS),
      .HIST_W      (HW),
      .START_CUR   (i == 0)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .thr       (thr_r),
      .cur_prev  (cur_vec[(i == 0) ? SLOTS-1 : i-1]),
      .cur_out   (cur_vec[i]),
      .wr_addr   (cur_cnt_r[AW-1:0]),
      .wr_data   (wr_data),
      .end_count (end_count),
      .rd_idx    (walk_r),
      .probe_x   (x_r),
      .probe_y   (y_r),
      .probe_r   (r_r),
      .cnt_in    (cnt_chain[i]),
      .cnt_out   (cnt_chain[i+1])
    );
  end

  // result word
  logic [HW-1:0]   matched;
  logic [HW+2:0]   matched_ext;
  logic            stable_bit;
  logic [OUT_DW-1:0] res_data;

  always_comb begin
    matched     = inside_r ? cnt_chain[SLOTS] : '0;
    matched_ext = {3'b000, matched};
    stable_bit  = inside_r && (matched_ext > {{HW{1'b0}}, match_thr_r});
    res_data    = '0;
    if (has_r) begin
      res_data[CB-1:0]        = x_r;
      res_data[2*CB-1:CB]     = y_r;
      res_data[3*CB-1:2*CB]   = r_r;
      res_data[3*CB]          = inside_r;
      res_data[3*CB+3:3*CB+1] = matched_ext[2:0];
      res_data[3*CB+4]        = stable_bit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_tdata <= res_data;
      out_tuser <= has_r;
      out_tlast <= ends_r;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

// ===== sim/stable_circle_tracker_checker.sv =====
module stable_circle_tracker_checker #(
  parameter int HISTORY_DEPTH = 5,
  parameter int MAX_CIRCLES   = 16,
  parameter int COORD_BITS    = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: centre_x, centre_y, radius, zero fill
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]   in_tdata,
  // in_tuser: mode
  input  logic [sct_pkg::MODE_W-1:0]          in_tuser,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  // out_tdata: out_centre_x, out_centre_y, out_radius, inside_frame,
  // matched_frames, stable, zero fill
  input  logic [((3*COORD_BITS+5+7)/8)*8-1:0] out_tdata,
  // out_tuser: circle_present
  input  logic                                out_tuser,
  input  logic                                out_tlast,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [sct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sct_pkg::DIM_W-1:0]           cfg_wdata,
  output int                                  mismatches,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import sct_pkg::*;

  localparam int SLOTS = HISTORY_DEPTH + 1;
  localparam int C     = COORD_BITS;

  typedef logic [C-1:0] coord_t;

  typedef struct packed {
    logic         present;
    coord_t       x;
    coord_t       y;
    coord_t       r;
    logic         in_image;
    logic [2:0]   matched;
    logic         stable;
    logic         done;
  } track_result_t;

  // history ring: one slot per frame, the current frame fills cur_slot
  coord_t      hist_x [SLOTS][MAX_CIRCLES];
  coord_t      hist_y [SLOTS][MAX_CIRCLES];
  coord_t      hist_r [SLOTS][MAX_CIRCLES];
  int unsigned slot_fill [SLOTS];
  int unsigned cur_slot;
  int unsigned frames_held;
  int unsigned frame_fill;

  // register copies
  logic [THR_W-1:0]   x_thr, y_thr, r_thr;
  logic [MATCH_W-1:0] match_thr;
  logic [DIM_W-1:0]   img_w, img_h;

  track_result_t expected_q[$];
  track_result_t oldest;

  function automatic int unsigned coord_gap(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // does a finished slot hold a circle close to (x, y, r)
  function automatic bit slot_similar(int unsigned s, coord_t x, coord_t y, coord_t r);
    int unsigned n;
    n = (slot_fill[s] > MAX_CIRCLES) ? MAX_CIRCLES : slot_fill[s];
    for (int unsigned k = 0; k < n; k++) begin
      if (coord_gap(x, hist_x[s][k]) < x_thr &&
          coord_gap(y, hist_y[s][k]) < y_thr &&
          coord_gap(r, hist_r[s][k]) < r_thr)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // predicted result of one input word, advancing the history
  function automatic track_result_t track_word(logic [1:0] mode, coord_t x, coord_t y,
                                               coord_t r);
    track_result_t res;
    bit            has_circle;
    bit            closes;
    int unsigned   depth_used;
    int unsigned   s;
    int unsigned   hits;
    res        = '0;
    hits       = 0;
    has_circle = (mode == MODE_CIRCLE) || (mode == MODE_CIRCLE_END);
    closes     = (mode != MODE_CIRCLE);
    if (has_circle) begin
      res.present  = 1'b1;
      res.x        = x;
      res.y        = y;
      res.r        = r;
      res.in_image = (x >= r) && (y >= r) &&
                     (int'(x) + int'(r) < 4 * int'(img_w)) &&
                     (int'(y) + int'(r) < 4 * int'(img_h));
      if (res.in_image) begin
        depth_used = (frames_held > HISTORY_DEPTH) ? HISTORY_DEPTH : frames_held;
        for (int unsigned i = 1; i <= depth_used; i++) begin
          s = (cur_slot + SLOTS - i) % SLOTS;
          if (slot_similar(s, x, y, r))
            hits++;
        end
        res.stable = (hits > match_thr);
      end
      res.matched = 3'(hits);
      // circles past the frame capacity are reported but dropped
      if (frame_fill < MAX_CIRCLES) begin
        hist_x[cur_slot][frame_fill] = x;
        hist_y[cur_slot][frame_fill] = y;
        hist_r[cur_slot][frame_fill] = r;
        frame_fill++;
      end
    end
    if (closes) begin
      slot_fill[cur_slot] = frame_fill;
      cur_slot            = (cur_slot + 1) % SLOTS;
      if (frames_held < HISTORY_DEPTH)
        frames_held++;
      frame_fill = 0;
      res.done   = 1'b1;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++)
        slot_fill[s] = 0;
      cur_slot    = 0;
      frames_held = 0;
      frame_fill  = 0;
      x_thr       = X_THR_RST;
      y_thr       = Y_THR_RST;
      r_thr       = R_THR_RST;
      match_thr   = MATCH_THR_RST;
      img_w       = FRAME_W_RST;
      img_h       = FRAME_H_RST;
      expected_q.delete();
    end else begin
      // result word against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatches++;
        end else begin
          oldest = expected_q[0];
          expected_q.delete(0);
          check_field("circle_present", oldest.present, out_tuser);
          check_field("out_centre_x", oldest.x, out_tdata[C-1:0]);
          check_field("out_centre_y", oldest.y, out_tdata[2*C-1:C]);
          check_field("out_radius", oldest.r, out_tdata[3*C-1:2*C]);
          check_field("inside_frame", oldest.in_image, out_tdata[3*C]);
          check_field("matched_frames", oldest.matched, out_tdata[3*C+3:3*C+1]);
          check_field("stable", oldest.stable, out_tdata[3*C+4]);
          check_field("frame_done", oldest.done, out_tlast);
        end
      end
      // accepted input word
      if (in_tvalid && in_tready)
        expected_q.insert(expected_q.size(),
                          track_word(in_tuser, in_tdata[C-1:0], in_tdata[2*C-1:C],
                                     in_tdata[3*C-1:2*C]));
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_X_THR:     x_thr     = cfg_wdata[THR_W-1:0];
          REG_Y_THR:     y_thr     = cfg_wdata[THR_W-1:0];
          REG_R_THR:     r_thr     = cfg_wdata[THR_W-1:0];
          REG_MATCH_THR: match_thr = cfg_wdata[MATCH_W-1:0];
          REG_FRAME_W:   img_w     = cfg_wdata;
          REG_FRAME_H:   img_h     = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== sim/stable_circle_tracker_tb.sv =====
module stable_circle_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sct_pkg::*;

  localparam int C     = 14;
  localparam int IN_W  = ((3*C+7)/8)*8;
  localparam int OUT_W = ((3*C+5+7)/8)*8;

  // word kinds not named in the package
  localparam logic [1:0] MODE_FRAME_END = 2'd2;
  localparam logic [1:0] MODE_SPARE     = 2'd3;

  localparam int COORD_MAX      = (1 << C) - 1;
  localparam int STALL_LIMIT    = 2000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_CIRCLES_TB = 16;

  logic                 clk;
  logic                 rst_n;
  logic [IN_W-1:0]      in_tdata;
  logic [MODE_W-1:0]    in_tuser;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_wdata;

  int mismatches;
  int pending;
  int stuck_cycles;
  int words_sent;
  bit steady;
  bit rx_hold_req;
  int rx_hold_left;
  int rx_gap_left;

  // register values as last written, in register order
  int cfg_vals[6] = '{60, 60, 80, 3, 640, 480};

  // tracked objects that drift from frame to frame
  int obj_x[3];
  int obj_y[3];
  int obj_r[3];

  typedef struct {
    int x;
    int y;
    int r;
  } circle_t;

  stable_circle_tracker i_dut (.*);

  stable_circle_tracker_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // result receiver: random stalls plus an optional long hold-off
  initial begin
    out_tready   = 1'b0;
    rx_hold_left = 0;
    rx_gap_left  = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req  = 1'b0;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        out_tready = 1'b0;
        rx_hold_left--;
      end else if (rx_gap_left > 0) begin
        out_tready = 1'b0;
        rx_gap_left--;
      end else begin
        out_tready = 1'b1;
        if (!steady && $urandom_range(0, 3) == 0)
          rx_gap_left = idle_len();
      end
    end
  end

  // offer one word and hold it until taken, then maybe idle
  task automatic send_word(logic [1:0] mode, int x, int y, int r);
    in_tuser           = mode;
    in_tdata           = '0;
    in_tdata[C-1:0]    = x[C-1:0];
    in_tdata[2*C-1:C]  = y[C-1:0];
    in_tdata[3*C-1:2*C] = r[C-1:0];
    in_tvalid          = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    words_sent++;
    if (!steady && $urandom_range(0, 2) == 0) begin
      in_tvalid = 1'b0;
      repeat (idle_len()) @(negedge clk);
    end
  endtask

  // stop sending until every predicted word has come out
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // random circle wholly inside the current image
  task automatic pick_inside(output int x, output int y, output int r);
    int w4;
    int h4;
    int rmax;
    w4   = 4 * cfg_vals[REG_FRAME_W];
    h4   = 4 * cfg_vals[REG_FRAME_H];
    rmax = (((w4 < h4) ? w4 : h4) - 1) / 2;
    if (rmax > 400)
      rmax = 400;
    r = $urandom_range(0, rmax);
    x = $urandom_range(r, w4 - 1 - r);
    y = $urandom_range(r, h4 - 1 - r);
  endtask

  // write all registers while idle, then pick fresh objects
  task automatic set_config(int xt, int yt, int rt, int mt, int w, int h);
    logic [CFG_IDX_W-1:0] reg_order[6];
    reg_order = '{REG_X_THR, REG_Y_THR, REG_R_THR, REG_MATCH_THR, REG_FRAME_W, REG_FRAME_H};
    drain_results();
    cfg_vals = '{xt, yt, rt, mt, w, h};
    cfg_we   = 1'b1;
    for (int k = 0; k < 6; k++) begin
      cfg_index = reg_order[k];
      cfg_wdata = cfg_vals[k][DIM_W-1:0];
      @(negedge clk);
    end
    cfg_we = 1'b0;
    for (int k = 0; k < 3; k++)
      pick_inside(obj_x[k], obj_y[k], obj_r[k]);
  endtask

  // one frame: noise circles, drifting objects, then the frame end
  task automatic send_frame(bit fill_up);
    circle_t list[$];
    circle_t c;
    int      extra;
    int      lim;
    bit      tail_closes;
    // bare frame end now and then
    if (!fill_up && $urandom_range(0, 11) == 0) begin
      send_word($urandom_range(0, 1) ? MODE_FRAME_END : MODE_SPARE,
                $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX));
      return;
    end
    extra = fill_up ? $urandom_range(MAX_CIRCLES_TB, MAX_CIRCLES_TB + 3) : $urandom_range(0, 2);
    for (int k = 0; k < extra; k++) begin
      if (!fill_up && $urandom_range(0, 1)) begin
        c.x = $urandom_range(0, COORD_MAX);
        c.y = $urandom_range(0, COORD_MAX);
        c.r = $urandom_range(0, COORD_MAX);
      end else begin
        pick_inside(c.x, c.y, c.r);
      end
      list.insert(list.size(), c);
    end
    // objects jitter around both sides of the thresholds
    lim = (cfg_vals[REG_X_THR] > 60) ? 60 : cfg_vals[REG_X_THR];
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 19) == 0)
        pick_inside(obj_x[k], obj_y[k], obj_r[k]);
      if (fill_up || $urandom_range(0, 4) != 0) begin
        c.x = clamp_coord(obj_x[k] + int'($urandom_range(0, 2*lim + 8)) - (lim + 4));
        c.y = clamp_coord(obj_y[k] + int'($urandom_range(0, 2*lim + 8)) - (lim + 4));
        c.r = clamp_coord(obj_r[k] + int'($urandom_range(0, 2*lim + 8)) - (lim + 4));
        list.insert(list.size(), c);
      end
    end
    tail_closes = (list.size() != 0) && $urandom_range(0, 1);
    foreach (list[k])
      send_word((tail_closes && k == list.size() - 1) ? MODE_CIRCLE_END : MODE_CIRCLE,
                list[k].x, list[k].y, list[k].r);
    if (!tail_closes)
      send_word($urandom_range(0, 3) != 0 ? MODE_FRAME_END : MODE_SPARE,
                $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX));
  endtask

  // random frames, with one pause for a full drain midway
  task automatic run_random(int n);
    int start;
    bit paused;
    start  = words_sent;
    paused = 1'b0;
    while (words_sent - start < n) begin
      send_frame(1'b0);
      if (!paused && words_sent - start >= n / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = MODE_CIRCLE;
    cfg_we      = 1'b0;
    cfg_index   = REG_X_THR;
    cfg_wdata   = '0;
    steady      = 1'b0;
    rx_hold_req = 1'b0;
    words_sent  = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed words at the reset settings (image 2560 x 1920 quarter pixels)
    send_word(MODE_FRAME_END, COORD_MAX, COORD_MAX, COORD_MAX);
    send_word(MODE_SPARE, 1234, 5678, 4321);
    send_word(MODE_CIRCLE, 0, 0, 0);
    send_word(MODE_CIRCLE, COORD_MAX, COORD_MAX, COORD_MAX);
    send_word(MODE_CIRCLE, 100, 100, 101);
    send_word(MODE_CIRCLE, 2259, 500, 300);
    send_word(MODE_CIRCLE, 2260, 500, 300);
    send_word(MODE_CIRCLE, 500, 1619, 300);
    send_word(MODE_CIRCLE_END, 500, 1620, 300);
    // same circle over several frames builds up to stable
    repeat (5) send_word(MODE_CIRCLE_END, 1000, 1000, 200);
    // threshold edges against a full history
    send_word(MODE_CIRCLE, 1059, 1000, 200);
    send_word(MODE_CIRCLE, 1060, 1000, 200);
    send_word(MODE_CIRCLE, 1000, 941, 279);
    send_word(MODE_CIRCLE, 1000, 1000, 280);
    send_word(MODE_CIRCLE, 1000, 1000, 200);
    send_word(MODE_CIRCLE_END, 1000, 1000, 200);

    // widest limits and image, always stable once matched
    set_config(1023, 1023, 1023, 0, 4095, 4095);
    send_frame(1'b1);
    run_random(110);

    // nothing can match, smallest image
    set_config(0, 0, 0, 5, 1, 1);
    run_random(60);

    // back-to-back words while the receiver holds off
    set_config(60, 60, 80, 3, 640, 480);
    steady      = 1'b1;
    rx_hold_req = 1'b1;
    run_random(110);
    steady = 1'b0;

    // match threshold beyond the history depth
    set_config($urandom_range(8, 120), $urandom_range(8, 120), $urandom_range(8, 120),
               7, $urandom_range(64, 4095), $urandom_range(64, 4095));
    send_frame(1'b1);
    run_random(100);

    repeat (3) begin
      set_config($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(8, 120),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(8, 120),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(8, 120),
                 $urandom_range(0, 5), $urandom_range(64, 4095), $urandom_range(64, 4095));
      run_random(70);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
